[rtl/nsng_pkg.sv]
// ----------------------------------------------------------------------------
// nsng_pkg: shared types and microcode for the 5-smooth number generator
// Holds the control word layout, step codes and the read-only program that
// drives the table-growth datapath.
// ----------------------------------------------------------------------------
package nsng_pkg;

    localparam int IDX_W = 11;   // width of the index field
    localparam int VAL_W = 32;   // width of a table entry and of the result
    localparam int CAND_W = 35;  // wide enough for an entry times 5

    typedef logic [2:0] step_t;

    localparam step_t ST_WAIT   = 3'd0;
    localparam step_t ST_CHECK  = 3'd1;
    localparam step_t ST_TEST   = 3'd2;
    localparam step_t ST_RD3    = 3'd3;
    localparam step_t ST_RD5    = 3'd4;
    localparam step_t ST_APPEND = 3'd5;
    localparam step_t ST_RDRES  = 3'd6;
    localparam step_t ST_OUT    = 3'd7;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_P2,
        RD_P3,
        RD_P5,
        RD_RES
    } rd_sel_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_ACCEPT,
        C_OOR,
        C_HAVE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        logic    ld_index;
        logic    ld_c2;
        logic    ld_c3;
        logic    append;
        logic    deliver;
        cond_t   cond;
        step_t   target;
    } ctrl_t;

    // Program: wait, range check, then loop {read p2, p3, p5, append} until
    // the table covers the index, read the entry and hand it out.
    function automatic ctrl_t ucode(step_t pc);
        ctrl_t w;
        begin
            w = '{rd_sel: RD_NONE, ld_index: 1'b0, ld_c2: 1'b0, ld_c3: 1'b0,
                  append: 1'b0, deliver: 1'b0, cond: C_NEVER, target: ST_WAIT};
            unique case (pc)
                ST_WAIT:
                begin
                    w.ld_index = 1'b1;
                    w.cond     = C_NOT_ACCEPT;
                    w.target   = ST_WAIT;
                end
                ST_CHECK:
                begin
                    w.cond   = C_OOR;
                    w.target = ST_OUT;
                end
                ST_TEST:
                begin
                    w.rd_sel = RD_P2;
                    w.cond   = C_HAVE;
                    w.target = ST_RDRES;
                end
                ST_RD3:
                begin
                    w.rd_sel = RD_P3;
                    w.ld_c2  = 1'b1;
                end
                ST_RD5:
                begin
                    w.rd_sel = RD_P5;
                    w.ld_c3  = 1'b1;
                end
                ST_APPEND:
                begin
                    w.append = 1'b1;
                    w.cond   = C_ALWAYS;
                    w.target = ST_TEST;
                end
                ST_RDRES:
                begin
                    w.rd_sel = RD_RES;
                end
                ST_OUT:
                begin
                    // falls through to ST_WAIT once the word is loaded
                    w.deliver = 1'b1;
                    w.cond    = C_OUT_BUSY;
                    w.target  = ST_OUT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

[rtl/nsng_ram.sv]
// ----------------------------------------------------------------------------
// nsng_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module nsng_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/nth_smooth_number_generator.sv]
// ----------------------------------------------------------------------------
// nth_smooth_number_generator: nth number of the form 2^p * 3^q * 5^r
// A microcoded sequencer grows an ordered table in RAM with three merge
// pointers and answers each index from that table.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+-------------------
//  in      | in_valid, in_ready, index        | sink      | 11-bit index
//  out     | out_valid, out_ready, value,     | source    | 32-bit value and
//          | out_of_range                     |           | range flag
//
//  Flow: a request already covered by the table runs WAIT, CHECK, TEST,
//  RDRES and OUT; an out-of-range index runs WAIT, CHECK and OUT; each new
//  table entry adds TEST, RD3, RD5 and APPEND (one RAM read port is shared
//  by the three pointer reads).
//  Reset: the table count and pointers clear at once; no clearing pass.
//  Stalls: a new index is taken while a result waits; the sequencer holds in
//  its output step only if the next result is ready before out_ready.
// ----------------------------------------------------------------------------
module nth_smooth_number_generator
    import nsng_pkg::*;
#(
    parameter int MAX_INDEX = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IDX_W-1:0]     index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VAL_W-1:0]     value,
    output logic                 out_of_range
);

    localparam int AW = $clog2(MAX_INDEX);
    localparam int CW = $clog2(MAX_INDEX + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_INDEX);

    step_t             pc_reg, pc_next;
    ctrl_t             cw;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     p2_reg, p2_next;
    logic [AW-1:0]     p3_reg, p3_next;
    logic [AW-1:0]     p5_reg, p5_next;
    logic [CAND_W-1:0] c2_reg, c2_next;
    logic [CAND_W-1:0] c3_reg, c3_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic              oor_reg, oor_next;

    logic              accept;
    logic              oor;
    logic              have;
    logic              out_busy;
    logic              take;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [VAL_W-1:0]  ram_rdata;
    logic [CAND_W-1:0] c5;
    logic [CAND_W-1:0] cmin;

    assign cw       = ucode(pc_reg);
    assign in_ready = (pc_reg == ST_WAIT);
    assign accept   = in_valid && in_ready;
    assign oor      = (idx_reg == '0) || (idx_reg > MAX_IDX);
    assign have     = IDX_W'(count_reg) >= idx_reg;
    assign out_busy = out_valid_reg && !out_ready;

    // candidate for the five pointer comes straight from the read data
    assign c5   = (CAND_W'(ram_rdata) << 2) + CAND_W'(ram_rdata);

    always_comb
    begin
        cmin = c2_reg;
        if (c3_reg < cmin)
        begin
            cmin = c3_reg;
        end
        if (c5 < cmin)
        begin
            cmin = c5;
        end
    end

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NOT_ACCEPT: take = !accept;
            C_OOR:        take = oor;
            C_HAVE:       take = have;
            C_OUT_BUSY:   take = out_busy;
            default:      take = 1'b0;
        endcase
        pc_next = take ? cw.target : step_t'(pc_reg + 3'd1);
    end

    always_comb
    begin
        ram_re    = 1'b1;
        ram_raddr = p2_reg;
        unique case (cw.rd_sel)
            RD_NONE: ram_re    = 1'b0;
            RD_P2:   ram_raddr = p2_reg;
            RD_P3:   ram_raddr = p3_reg;
            RD_P5:   ram_raddr = p5_reg;
            RD_RES:  ram_raddr = AW'(idx_reg - IDX_W'(1));
            default: ram_re    = 1'b0;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        count_next     = count_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        p5_next        = p5_reg;
        c2_next        = c2_reg;
        c3_next        = c3_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        oor_next       = oor_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(count_reg);
        ram_wdata      = cmin[VAL_W-1:0];

        if (cw.ld_index && accept)
        begin
            idx_next = index;
        end
        if (cw.ld_c2)
        begin
            c2_next = CAND_W'(ram_rdata) << 1;
        end
        if (cw.ld_c3)
        begin
            c3_next = (CAND_W'(ram_rdata) << 1) + CAND_W'(ram_rdata);
        end
        if (cw.append)
        begin
            ram_we     = 1'b1;
            count_next = count_reg + CW'(1);
            if (count_reg == '0)
            begin
                // seed the empty table with 1
                ram_wdata = VAL_W'(1);
            end
            else
            begin
                // advance every pointer whose candidate matched, drop duplicates
                if (c2_reg == cmin)
                begin
                    p2_next = p2_reg + AW'(1);
                end
                if (c3_reg == cmin)
                begin
                    p3_next = p3_reg + AW'(1);
                end
                if (c5 == cmin)
                begin
                    p5_next = p5_reg + AW'(1);
                end
            end
        end
        if (cw.deliver && !out_busy)
        begin
            out_valid_next = 1'b1;
            oor_next       = oor;
            value_next     = oor ? '0 : ram_rdata;
        end
    end

    nsng_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_INDEX)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_WAIT;
            count_reg     <= '0;
            p2_reg        <= '0;
            p3_reg        <= '0;
            p5_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            p2_reg        <= p2_next;
            p3_reg        <= p3_next;
            p5_reg        <= p5_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        c2_reg    <= c2_next;
        c3_reg    <= c3_next;
        value_reg <= value_next;
        oor_reg   <= oor_next;
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign out_of_range = oor_reg;

    a_ptr_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> ((CW'(p2_reg) < count_reg) && (CW'(p3_reg) < count_reg)
                               && (CW'(p5_reg) < count_reg)))
        else $error("merge pointer reached unwritten entry");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(MAX_INDEX) >= count_reg)
        else $error("table count beyond depth");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg >= $past(count_reg)))
        else $error("table count went down");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oor_reg) |-> (value_reg == '0))
        else $error("out-of-range word carries a value");

    a_append_only_growing: assert property (@(posedge clk) disable iff (!rst_n)
        cw.append |-> (IDX_W'(count_reg) < idx_reg))
        else $error("append past requested index");

endmodule

[test/nth_smooth_number_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nth_smooth_number_generator_tb: self-checking bench for the 5-smooth generator
// Sends indexes through the valid/ready input channel and predicts each answer
// from a table of its own, grown by the three-pointer merge. Every result
// word is checked against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module nth_smooth_number_generator_tb;

    import nsng_pkg::IDX_W;
    import nsng_pkg::VAL_W;

    localparam int MAX_INDEX = 1024;
    localparam int DIRECTED_N = 19;
    localparam int RANDOM_N = 560;
    localparam int DIRECTED[DIRECTED_N] = '{0, 1, 1, 2, 6, 7, 8, 5, 1025, 2047, 1536, 0,
                                           16, 15, 12, 1, 30, 2, 24};

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             oor;
    } answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [IDX_W-1:0] index = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [VAL_W-1:0] value;
    logic             out_of_range;

    logic [IDX_W-1:0] index_q[$];
    answer_t          answers[$];
    int               err_cnt = 0;
    int               tx_wait = 0;
    int               tx_quiet = 0;
    int               rx_wait = 0;
    int               rx_quiet = 0;

    // Own copy of the sorted 5-smooth table and its merge pointers
    logic [VAL_W-1:0] hamming_tbl[MAX_INDEX];
    int unsigned      tbl_fill = 0;
    int unsigned      at2 = 0;
    int unsigned      at3 = 0;
    int unsigned      at5 = 0;

    nth_smooth_number_generator #(
        .MAX_INDEX (MAX_INDEX)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .index        (index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .out_of_range (out_of_range)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void grow_table();
        logic [63:0] c2;
        logic [63:0] c3;
        logic [63:0] c5;
        logic [63:0] m;
        if (tbl_fill >= MAX_INDEX)
            return;
        if (tbl_fill == 0)
        begin
            hamming_tbl[0] = 1;
            tbl_fill = 1;
            return;
        end
        c2 = 64'(hamming_tbl[at2]) * 2;
        c3 = 64'(hamming_tbl[at3]) * 3;
        c5 = 64'(hamming_tbl[at5]) * 5;
        m = c2;
        if (c3 < m)
            m = c3;
        if (c5 < m)
            m = c5;
        hamming_tbl[tbl_fill] = m[VAL_W-1:0];
        tbl_fill++;
        // advance every pointer that produced the minimum, so duplicates drop out
        if (c2 == m)
            at2++;
        if (c3 == m)
            at3++;
        if (c5 == m)
            at5++;
    endfunction

    function automatic answer_t smooth_at(logic [IDX_W-1:0] n);
        answer_t a;
        if (n == 0 || n > MAX_INDEX)
        begin
            a.value = '0;
            a.oor = 1'b1;
            return a;
        end
        while (tbl_fill < n)
            grow_table();
        a.value = hamming_tbl[n - 1];
        a.oor = 1'b0;
        return a;
    endfunction

    // Input driver: present one index word at a time, gap drawn per word
    always @(posedge clk or negedge rst_n)
    begin : feed
        int w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            index <= '0;
            tx_wait <= 0;
            tx_quiet <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                answers.push_back(smooth_at(index));
            // hold valid and index until the word is taken
            if (!in_valid || in_ready)
            begin
                if (tx_wait != 0)
                begin
                    in_valid <= 1'b0;
                    tx_wait <= tx_wait - 1;
                end
                else if (index_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    index <= index_q.pop_front();
                    if (tx_quiet != 0)
                    begin
                        w = 0;
                        tx_quiet <= tx_quiet - 1;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        w = 0;
                        tx_quiet <= $urandom_range(8, 40);
                    end
                    else
                        w = $urandom_range(0, 19);
                    tx_wait <= w;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: stall ready per result word and check against predictions
    always @(posedge clk or negedge rst_n)
    begin : drain
        answer_t a;
        int      w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait <= 0;
            rx_quiet <= 0;
        end
        else
        begin
            w = rx_wait;
            if (out_valid && out_ready)
            begin
                if (answers.size() == 0)
                begin
                    $error("unexpected result word: value %0d, out_of_range %0b",
                           value, out_of_range);
                    err_cnt++;
                end
                else
                begin
                    a = answers.pop_front();
                    if (value !== a.value)
                    begin
                        $error("value: expected %0d, got %0d", a.value, value);
                        err_cnt++;
                    end
                    if (out_of_range !== a.oor)
                    begin
                        $error("out_of_range: expected %0b, got %0b", a.oor, out_of_range);
                        err_cnt++;
                    end
                end
                if (rx_quiet != 0)
                begin
                    w = 0;
                    rx_quiet <= rx_quiet - 1;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    w = 0;
                    rx_quiet <= $urandom_range(8, 40);
                end
                else
                    w = $urandom_range(0, 19);
            end
            else if (w != 0)
                w = w - 1;
            rx_wait <= w;
            out_ready <= (w == 0);
        end
    end

    initial
    begin
        int n;
        int frontier;
        int pick;
        int lo;
        int hi;
        frontier = 0;
        foreach (DIRECTED[i])
        begin
            index_q.push_back(IDX_W'(DIRECTED[i]));
            if (DIRECTED[i] <= MAX_INDEX && DIRECTED[i] > frontier)
                frontier = DIRECTED[i];
        end
        // Mostly walk just around the grown part of the table, so growth comes
        // in small steps all the way up; mix in covered hits and bad indexes.
        for (int k = 0; k < RANDOM_N; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                lo = (frontier > 12) ? frontier - 12 : 1;
                hi = (frontier + 12 < MAX_INDEX) ? frontier + 12 : MAX_INDEX;
                n = $urandom_range(lo, hi);
            end
            else if (pick < 85)
                n = $urandom_range(1, (frontier > 1) ? frontier : 1);
            else if (pick < 92)
                n = 0;
            else
                n = $urandom_range(MAX_INDEX + 1, (1 << IDX_W) - 1);
            if (n <= MAX_INDEX && n > frontier)
                frontier = n;
            index_q.push_back(IDX_W'(n));
        end
        index_q.push_back(IDX_W'(MAX_INDEX));
        index_q.push_back(IDX_W'(MAX_INDEX - 1));
        index_q.push_back(IDX_W'(1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (index_q.size() != 0 || in_valid)
            @(posedge clk);
        while (answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
